>>> hdl/bc1_pkg.sv
// Shared types and constants for the BC1 block decoder.
package bc1_pkg;

	localparam int CFG_W      = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int BLK_CNT_W  = 10;
	localparam int BLK_LIM_W  = BLK_CNT_W + 1;
	localparam int COORD_W    = 12;
	localparam int PIX_W      = 32;
	localparam int CHAN_W     = 8;

	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(256);
	localparam logic [BLK_LIM_W-1:0] BLK_LIMIT = BLK_LIM_W'(1024);

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

	localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

	localparam logic [1:0] CODE_C0   = 2'd0;
	localparam logic [1:0] CODE_C1   = 2'd1;
	localparam logic [1:0] CODE_MIX2 = 2'd2;
	localparam logic [1:0] CODE_MIX3 = 2'd3;

	typedef struct packed {
		logic [15:0] color_a;
		logic [15:0] color_b;
		logic [31:0] index_bits;
	} bc1_block_t;

	typedef struct packed {
		logic [PIX_W-1:0]   pixel_left;
		logic [PIX_W-1:0]   pixel_second;
		logic [PIX_W-1:0]   pixel_third;
		logic [PIX_W-1:0]   pixel_right;
		logic [COORD_W-1:0] row_y;
		logic [COORD_W-1:0] column_x;
		logic               last_row;
	} bc1_row_t;

	typedef logic [3:0][PIX_W-1:0] bc1_pal_t;

	typedef struct packed {
		logic [BLK_CNT_W-1:0] blk_row;
		logic [BLK_CNT_W-1:0] blk_col;
	} bc1_coord_t;

endpackage

>>> hdl/bc1_palette.sv
// Endpoint expansion and four-entry palette build for one block.
module bc1_palette import bc1_pkg::*; (
	input  logic [15:0] color_a,
	input  logic [15:0] color_b,
	output bc1_pal_t    pal
);

	// x/3 for x < 1024 via reciprocal multiply
	function automatic logic [CHAN_W-1:0] div3(input logic [9:0] x);
		logic [19:0] p;
		p = x * 10'd683;
		return p[18:11];
	endfunction

	logic [CHAN_W-1:0] r0, g0, b0, r1, g1, b1;
	logic [CHAN_W-1:0] r2, g2, b2, r3, g3, b3;
	logic [CHAN_W-1:0] rm, gm, bm;
	logic [8:0] sr, sg, sb;

	always_comb begin
		r0 = {color_a[15:11], 3'b000};
		g0 = {color_a[10:5], 2'b00};
		b0 = {color_a[4:0], 3'b000};
		r1 = {color_b[15:11], 3'b000};
		g1 = {color_b[10:5], 2'b00};
		b1 = {color_b[4:0], 3'b000};

		r2 = div3({1'b0, r0, 1'b0} + 10'(r1));
		g2 = div3({1'b0, g0, 1'b0} + 10'(g1));
		b2 = div3({1'b0, b0, 1'b0} + 10'(b1));
		r3 = div3(10'(r0) + {1'b0, r1, 1'b0});
		g3 = div3(10'(g0) + {1'b0, g1, 1'b0});
		b3 = div3(10'(b0) + {1'b0, b1, 1'b0});

		sr = 9'(r0) + 9'(r1);
		sg = 9'(g0) + 9'(g1);
		sb = 9'(b0) + 9'(b1);
		rm = sr[8:1];
		gm = sg[8:1];
		bm = sb[8:1];

		pal[0] = {ALPHA_OPAQUE, b0, g0, r0};
		pal[1] = {ALPHA_OPAQUE, b1, g1, r1};
		if (color_a > color_b) begin
			pal[2] = {ALPHA_OPAQUE, b2, g2, r2};
			pal[3] = {ALPHA_OPAQUE, b3, g3, r3};
		end else begin
			pal[2] = {ALPHA_OPAQUE, bm, gm, rm};
			pal[3] = '0;    // transparent black
		end
	end

endmodule

>>> hdl/bc1_lane.sv
// One pixel lane: maps a 2-bit code onto the block palette.
module bc1_lane import bc1_pkg::*; (
	input  bc1_pal_t          pal,
	input  logic [1:0]        code,
	output logic [PIX_W-1:0]  pixel
);

	always_comb begin
		case (code)
			CODE_C0:   pixel = pal[0];
			CODE_C1:   pixel = pal[1];
			CODE_MIX2: pixel = pal[2];
			CODE_MIX3: pixel = pal[3];
			default:   pixel = pal[0];
		endcase
	end

endmodule

>>> hdl/bc1_block_counter.sv
// Image size registers and block column/row counters.
module bc1_block_counter import bc1_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 advance,
	output bc1_coord_t           coord
);

	localparam int SZ_W = 16;

	function automatic logic [BLK_LIM_W-1:0] blocks_along(input logic [CFG_W-1:0] size,
			input int unsigned max_size);
		logic [SZ_W-1:0] s;
		logic [SZ_W-3:0] n;
		s = SZ_W'(size);
		if (s < SZ_W'(4)) s = SZ_W'(4);
		if (s > SZ_W'(max_size)) s = SZ_W'(max_size);
		n = s[SZ_W-1:2];
		if (n > (SZ_W-2)'(BLK_LIMIT)) return BLK_LIMIT;
		return n[BLK_LIM_W-1:0];
	endfunction

	logic [CFG_W-1:0] width_q, height_q;
	logic [BLK_CNT_W-1:0] col_q, row_q;
	logic [BLK_LIM_W-1:0] cols, rows, col_nx, row_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_RESET;
			height_q <= SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cols   = blocks_along(width_q, MAX_WIDTH);
		rows   = blocks_along(height_q, MAX_HEIGHT);
		col_nx = BLK_LIM_W'(col_q) + 1'b1;
		row_nx = BLK_LIM_W'(row_q) + 1'b1;
	end

	// a column past the limit after a size change wraps on the next step; a row wraps when the column does
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (col_nx >= cols) begin
				col_q <= '0;
				if (row_nx >= rows) row_q <= '0;
				else                row_q <= row_nx[BLK_CNT_W-1:0];
			end else begin
				col_q <= col_nx[BLK_CNT_W-1:0];
			end
		end
	end

	assign coord.blk_row = row_q;
	assign coord.blk_col = col_q;

endmodule

>>> hdl/bc1_block_decoder.sv
// BC1 block decoder top level: block buffer, row sequencer, lanes and output merge.
//
// Accepts one 64-bit BC1 block per word and delivers four row words per block, top row
// first, each holding four RGBA8888 pixels and the image coordinates of that row. The
// palette is built when the block is taken and held in a one-block buffer; four pixel
// lanes then decode one row per cycle into the output register, unless pixel_stall holds
// it. The output port moves one row word per cycle while not stalled; a new block is
// taken in the same cycle the last row of the previous one enters the output register.
// After accept, a block's first row word passes through the block buffer and then the
// output register. Image size registers are to be written through the cfg port only
// while the block is idle; the block does not enforce this. cfg_ready is always high.
module bc1_block_decoder import bc1_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 block_valid,
	output logic                 block_stall,
	input  bc1_block_t           block_data,
	output logic                 pixel_valid,
	input  logic                 pixel_stall,
	output bc1_row_t             pixel_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	bc1_pal_t    pal_new, pal_s1;
	logic [31:0] codes_s1;
	bc1_coord_t  coord, coord_s1;
	logic        valid_s1;
	logic [1:0]  row_q;
	logic        out_load, blk_take, blk_free;
	logic [7:0]  row_codes;
	logic [3:0][PIX_W-1:0] lane_pix;
	bc1_row_t    pix_q;
	logic        pix_valid_q;

	assign cfg_ready = 1'b1;

	bc1_palette u_palette (
		.color_a (block_data.color_a),
		.color_b (block_data.color_b),
		.pal     (pal_new)
	);

	bc1_block_counter #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_counter (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (blk_take),
		.coord     (coord)
	);

	// output register free or being drained
	assign out_load    = !pix_valid_q || !pixel_stall;
	assign blk_free    = valid_s1 && out_load && (row_q == 2'd3);
	assign block_stall = valid_s1 && !blk_free;
	assign blk_take    = block_valid && !block_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (blk_take) begin
			valid_s1 <= 1'b1;
		end else if (blk_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (blk_take) begin
			pal_s1   <= pal_new;
			codes_s1 <= block_data.index_bits;
			coord_s1 <= coord;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (valid_s1 && out_load) begin
			row_q <= row_q + 2'd1;
		end
	end

	assign row_codes = codes_s1[{row_q, 3'b000} +: 8];

	for (genvar i = 0; i < 4; i++) begin : g_lane
		bc1_lane u_lane (
			.pal   (pal_s1),
			.code  (row_codes[2*i +: 2]),
			.pixel (lane_pix[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (out_load) begin
			pix_valid_q <= valid_s1;
		end
	end

	// merge lanes with row coordinates
	always_ff @(posedge clk) begin
		if (out_load && valid_s1) begin
			pix_q.pixel_left   <= lane_pix[0];
			pix_q.pixel_second <= lane_pix[1];
			pix_q.pixel_third  <= lane_pix[2];
			pix_q.pixel_right  <= lane_pix[3];
			pix_q.row_y        <= {coord_s1.blk_row, row_q};
			pix_q.column_x     <= {coord_s1.blk_col, 2'b00};
			pix_q.last_row     <= (row_q == 2'd3);
		end
	end

	assign pixel_valid = pix_valid_q;
	assign pixel_data  = pix_q;

	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid |-> (pixel_data.last_row == (pixel_data.row_y[1:0] == 2'd3)))
		else $error("last_row flag does not match row within block");

	a_col_align: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid |-> (pixel_data.column_x[1:0] == 2'b00))
		else $error("column_x not block aligned");

	a_hold_block: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_load) |-> block_stall)
		else $error("block taken while buffer held and output blocked");

	a_take_fill: assert property (@(posedge clk) disable iff (!arst_n)
		blk_take |=> (valid_s1 && row_q == 2'd0))
		else $error("block buffer not loaded at row zero after accept");

endmodule
